// ===== rtl/bdde_pkg.sv =====
// Shared widths, event codes and limits for the button decimal digit editor.
package bdde_pkg;

  // Field widths of the request and result channels
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 27;
  localparam int DIGIT_W  = 4;
  localparam int CURSOR_W = 3;
  localparam int COUNT_W  = 4;

  // Packed channel widths, padded to whole bytes
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  // Button event codes
  localparam logic [FUNC_W-1:0] FUNC_UP    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DOWN  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_LEFT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd5;

  // Largest decimal digit, the reported value ceiling and the reset digit count
  localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 4'd9;
  localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

  typedef logic [DIGIT_W-1:0] digit_t;

endpackage

// ===== rtl/button_decimal_digit_editor.sv =====
// Button decimal digit editor: digit store, cursor and value reporting pipeline.
//
// Requests arrive on the s_axis channel: tuser carries the button event (up, down,
// left, right, push, load) and tdata the binary value used by a load. Every request
// produces exactly one result on the m_axis channel with the binary value of the
// digits in use, the cursor position and the digit under the cursor.
// The digit count is set through cfg_we / cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. A count of zero acts as one and
// a count above MAX_DIGITS acts as MAX_DIGITS. One request can be accepted every cycle while
// the result channel is not stalled. The stages are the input register (decimal split of the
// load value by reciprocal multiplication), the state update of digits and cursor, and the
// result register (weighted digit sum).
// Each stage holds when the one after it is full and stalled, so a stalled
// receiver backs requests up stage by stage until s_axis_tready falls.
// Synchronous reset clears all digits, puts the cursor on digit 0, sets the digit
// count to eight and empties the pipeline.
module button_decimal_digit_editor
  import bdde_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration: digit count
  input  logic                 cfg_we,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  // Request channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // [26:0] load_value, [31:27] zero
  input  logic [FUNC_W-1:0]    s_axis_tuser,   // [2:0] func
  // Result channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata    // [26:0] number_value, [29:27] cursor_pos,
                                               // [33:30] cursor_digit, [39:34] zero
);

  localparam int CW       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int MULT_W   = VALUE_W + 1;
  localparam int PROD_W   = VALUE_W + MULT_W;
  localparam longint unsigned FULL_MAX = (64'd10 ** MAX_DIGITS) - 64'd1;
  localparam int SUM_W    = $clog2(FULL_MAX + 64'd1);
  localparam int ACC_W    = (SUM_W > VALUE_W) ? SUM_W : VALUE_W;
  localparam int PAD_W    = M_TDATA_W - VALUE_W - CURSOR_W - DIGIT_W;

  // Pipeline handshake
  logic v1, v2;
  logic rdy1, rdy2, rdy3;

  // Input register contents
  logic [FUNC_W-1:0]  func1;
  digit_t             qlow1 [MAX_DIGITS+1];
  digit_t             qlow_in [MAX_DIGITS+1];

  // Block state
  logic [COUNT_W-1:0] digit_count;
  digit_t             digits [MAX_DIGITS];
  logic [CW-1:0]      cursor;
  digit_t             digits_next [MAX_DIGITS];
  logic [CW-1:0]      cursor_next;

  // Derived values
  logic [COUNT_W-1:0] act_n;
  logic [COUNT_W-1:0] n_m1;
  digit_t             cur_digit;
  digit_t             load_digit [MAX_DIGITS];
  logic [ACC_W-1:0]   term [MAX_DIGITS];
  logic [ACC_W-1:0]   acc;
  logic [VALUE_W-1:0] number_value;

  // Each stage moves on when it is empty or the next stage frees up
  assign rdy3          = !m_axis_tvalid || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // Low four bits of floor(load / 10^k), exact by reciprocal multiplication
  for (genvar k = 0; k <= MAX_DIGITS; k++) begin : g_split
    localparam longint unsigned DIV   = 64'd10 ** k;
    localparam int              SHIFT = VALUE_W + $clog2(DIV);
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W+DIGIT_W-1:0] prod_ext;

    assign prod     = PROD_W'(s_axis_tdata[VALUE_W-1:0]) * PROD_W'(RECIP);
    assign prod_ext = {{DIGIT_W{1'b0}}, prod};
    if (SHIFT >= PROD_W) begin : g_zero
      assign qlow_in[k] = '0;
    end else begin : g_slice
      assign qlow_in[k] = prod_ext[SHIFT +: DIGIT_W];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      func1 <= s_axis_tuser;
      qlow1 <= qlow_in;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_RESET;
    end else if (cfg_we) begin
      digit_count <= cfg_wdata;
    end
  end

  // Digit count in use, clamped to one and MAX_DIGITS
  always_comb begin
    if (digit_count == '0) begin
      act_n = COUNT_W'(1);
    end else if (digit_count > COUNT_W'(MAX_DIGITS)) begin
      act_n = COUNT_W'(MAX_DIGITS);
    end else begin
      act_n = digit_count;
    end
  end

  assign n_m1      = act_n - COUNT_W'(1);
  assign cur_digit = digits[cursor];

  // Decimal digit k is floor(v/10^k) - 10*floor(v/10^(k+1)); only four bits matter
  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_load
    logic [2*DIGIT_W-1:0] times10;

    assign times10       = {{DIGIT_W{1'b0}}, qlow1[k+1]} * 8'd10;
    assign load_digit[k] = qlow1[k] - times10[DIGIT_W-1:0];
  end

  // Next state for the event in the input register
  always_comb begin
    digits_next = digits;
    cursor_next = cursor;
    unique case (func1)
      FUNC_UP: begin
        digits_next[cursor] = (cur_digit >= DIGIT_MAX) ? '0 : cur_digit + digit_t'(1);
      end
      FUNC_DOWN: begin
        if (cur_digit == '0 || cur_digit > DIGIT_MAX) begin
          digits_next[cursor] = DIGIT_MAX;
        end else begin
          digits_next[cursor] = cur_digit - digit_t'(1);
        end
      end
      FUNC_LEFT: begin
        cursor_next = (COUNT_W'(cursor) >= n_m1) ? '0 : cursor + CW'(1);
      end
      FUNC_RIGHT: begin
        cursor_next = (cursor == '0) ? CW'(n_m1) : cursor - CW'(1);
      end
      FUNC_PUSH: begin
        cursor_next = '0;
      end
      FUNC_LOAD: begin
        digits_next = load_digit;
      end
      default: begin
      end
    endcase
  end

  // State update as the event leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2     <= 1'b0;
      cursor <= '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else begin
      if (rdy2) begin
        v2 <= v1;
      end
      if (v1 && rdy2) begin
        digits <= digits_next;
        cursor <= cursor_next;
      end
    end
  end

  // Weighted digits in use
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_term
    localparam longint unsigned PLACE = 64'd10 ** i;

    assign term[i] = (COUNT_W'(i) < act_n) ? ACC_W'(digits[i]) * ACC_W'(PLACE) : '0;
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      acc = acc + term[i];
    end
  end

  assign number_value = (acc > ACC_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(acc);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (rdy3) begin
      m_axis_tvalid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, cur_digit, CURSOR_W'(cursor), number_value};
    end
  end

endmodule

// ===== tb/button_decimal_digit_editor_tb.sv =====
// Self-checking testbench for the button decimal digit editor: digit edits, cursor moves and loads.
`timescale 1ns / 100ps

module button_decimal_digit_editor_tb;
  import bdde_pkg::*;

  localparam int MAX_DIGITS  = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 88;

  // Event codes that the block ignores.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  // One button request as queued for the driver, with the idle cycles before it.
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] load_value;
    int                 gap;
  } button_req_t;

  // What the block reports after one event.
  typedef struct {
    logic [VALUE_W-1:0]  number_value;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [DIGIT_W-1:0]  cursor_digit;
  } editor_view_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [26:0] load_value, [31:27] zero
  logic [FUNC_W-1:0]    s_axis_tuser = '0;   // [2:0] func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [26:0] number_value, [29:27] cursor_pos,
                                             // [33:30] cursor_digit, [39:34] zero

  // Mirror of the editor state used for prediction.
  logic [DIGIT_W-1:0]  digit_mirror [MAX_DIGITS];
  logic [CURSOR_W-1:0] cursor_mirror = '0;
  logic [COUNT_W-1:0]  count_mirror = COUNT_RESET;

  button_req_t  button_queue[$];
  editor_view_t pending_views[$];
  button_req_t  drive_req;
  editor_view_t want_view;
  int           gap_count = 0;
  int           stall_count = 0;
  int           err_count = 0;
  int           cycle_count = 0;
  bit           send_idle = 1'b1;
  bit           stall_en = 1'b1;

  button_decimal_digit_editor #(
    .MAX_DIGITS(MAX_DIGITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Applies one event to the mirrored state and returns the view the block should report.
  function automatic editor_view_t edit_digits(logic [FUNC_W-1:0] func,
                                                logic [VALUE_W-1:0] load_value);
    editor_view_t view;
    int           used;
    int           pos;
    longint       total;
    longint       place;
    int unsigned  rest;
    used = (count_mirror == 0) ? 1 : ((count_mirror > MAX_DIGITS) ? MAX_DIGITS : count_mirror);
    pos  = cursor_mirror;
    case (func)
      FUNC_UP: begin
        digit_mirror[pos] = (digit_mirror[pos] >= DIGIT_MAX) ? '0 : digit_mirror[pos] + 1'b1;
      end
      FUNC_DOWN: begin
        if (digit_mirror[pos] == 0 || digit_mirror[pos] > DIGIT_MAX)
          digit_mirror[pos] = DIGIT_MAX;
        else
          digit_mirror[pos] = digit_mirror[pos] - 1'b1;
      end
      FUNC_LEFT: begin
        cursor_mirror = (pos >= used - 1) ? '0 : CURSOR_W'(pos + 1);
      end
      FUNC_RIGHT: begin
        cursor_mirror = (pos == 0) ? CURSOR_W'(used - 1) : CURSOR_W'(pos - 1);
      end
      FUNC_PUSH: begin
        cursor_mirror = '0;
      end
      FUNC_LOAD: begin
        rest = load_value;
        for (int i = 0; i < MAX_DIGITS; i++) begin
          digit_mirror[i] = DIGIT_W'(rest % 10);
          rest = rest / 10;
        end
      end
      default: begin
      end
    endcase
    // Weighted sum over the digits in use, clipped to the field width.
    total = 0;
    place = 1;
    for (int i = 0; i < used; i++) begin
      total = total + digit_mirror[i] * place;
      place = place * 10;
    end
    if (total > VALUE_MAX) total = VALUE_MAX;
    view.number_value = VALUE_W'(total);
    view.cursor_pos   = cursor_mirror;
    view.cursor_digit = digit_mirror[cursor_mirror];
    return view;
  endfunction

  task automatic queue_request(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value, int gap);
    button_req_t req;
    req.func       = func;
    req.load_value = value;
    req.gap        = gap;
    button_queue.push_back(req);
  endtask

  // Waits until no request is queued, in flight or awaiting its result.
  task automatic wait_drained();
    @(negedge clk);
    while (button_queue.size() != 0 || pending_views.size() != 0 || s_axis_tvalid)
      @(negedge clk);
  endtask

  // Writes the digit count once the editor has gone quiet.
  task automatic write_digit_count(logic [COUNT_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    count_mirror = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver: predicts each accepted request, then presents the next one after its gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_count     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        pending_views.push_back(edit_digits(drive_req.func, drive_req.load_value));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (button_queue.size() != 0 && gap_count >= button_queue[0].gap) begin
          drive_req = button_queue.pop_front();
          gap_count     <= 0;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(S_TDATA_W - VALUE_W){1'b0}}, drive_req.load_value};
          s_axis_tuser  <= drive_req.func;
        end else begin
          if (button_queue.size() != 0) gap_count <= gap_count + 1;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_views.size() == 0) begin
          $display("%0t: unexpected result, tdata %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          want_view = pending_views.pop_front();
          if (m_axis_tdata[26:0] !== want_view.number_value) begin
            $display("%0t: number_value expected %0d, got %0d", $time,
                     want_view.number_value, m_axis_tdata[26:0]);
            err_count++;
          end
          if (m_axis_tdata[29:27] !== want_view.cursor_pos) begin
            $display("%0t: cursor_pos expected %0d, got %0d", $time,
                     want_view.cursor_pos, m_axis_tdata[29:27]);
            err_count++;
          end
          if (m_axis_tdata[33:30] !== want_view.cursor_digit) begin
            $display("%0t: cursor_digit expected %0d, got %0d", $time,
                     want_view.cursor_digit, m_axis_tdata[33:30]);
            err_count++;
          end
        end
        stall_count = stall_en ? $urandom_range(0, 3) : 0;
      end
      if (stall_count > 0) begin
        stall_count--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("button_decimal_digit_editor_tb failed");
      $finish;
    end
    cycle_count <= cycle_count + 1;
  end

  // Stimulus: directed cases first, then random phases under different digit counts.
  initial begin
    logic [COUNT_W-1:0] phase_counts [8];
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    int                 pick;

    phase_counts = '{4'd1, 4'd8, 4'd5, 4'd0, 4'd15, 4'd2, 4'd12, 4'd7};
    for (int i = 0; i < MAX_DIGITS; i++) digit_mirror[i] = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wrapping of digits, loads at the extremes, cursor wrap and ignored events.
    queue_request(FUNC_UP, '0, $urandom_range(0, 3));
    queue_request(FUNC_DOWN, '0, $urandom_range(0, 3));
    queue_request(FUNC_DOWN, '0, $urandom_range(0, 3));
    queue_request(FUNC_UP, '0, $urandom_range(0, 3));
    queue_request(FUNC_LOAD, 27'd99999999, $urandom_range(0, 3));
    queue_request(FUNC_UP, '0, $urandom_range(0, 3));
    queue_request(FUNC_LOAD, VALUE_MAX, $urandom_range(0, 3));
    queue_request(FUNC_LOAD, '0, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));
    queue_request(FUNC_LEFT, '0, $urandom_range(0, 3));
    queue_request(FUNC_SPARE_LO, VALUE_MAX, $urandom_range(0, 3));
    queue_request(FUNC_SPARE_HI, 27'h2AAAAAA, $urandom_range(0, 3));
    queue_request(FUNC_LOAD, 27'd87654321, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));
    queue_request(FUNC_PUSH, '0, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));

    // Cursor left beyond the digits in use after the count is lowered.
    write_digit_count(4'd3);
    queue_request(FUNC_UP, '0, $urandom_range(0, 3));
    queue_request(FUNC_DOWN, '0, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));
    queue_request(FUNC_LEFT, '0, $urandom_range(0, 3));

    // A count of zero acts as one digit.
    write_digit_count(4'd0);
    queue_request(FUNC_LEFT, '0, $urandom_range(0, 3));
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));

    // A count above the store size acts as the full store.
    write_digit_count(4'd15);
    queue_request(FUNC_RIGHT, '0, $urandom_range(0, 3));
    queue_request(FUNC_LOAD, VALUE_MAX, $urandom_range(0, 3));

    // Random phases; idling on both sides, neither, or one side only.
    for (int phase = 0; phase < 8; phase++) begin
      write_digit_count(phase_counts[phase]);
      send_idle = (phase % 4 == 0) || (phase % 4 == 2);
      stall_en  = (phase % 4 == 0) || (phase % 4 == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          func = (pick < 2) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
        else
          func = FUNC_W'($urandom_range(0, 5));
        case ($urandom_range(0, 2))
          0:       value = VALUE_W'($urandom);
          1:       value = VALUE_W'($urandom_range(0, 99999999));
          default: value = VALUE_W'($urandom_range(0, 999));
        endcase
        queue_request(func, value, send_idle ? $urandom_range(0, 3) : 0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("button_decimal_digit_editor_tb passed");
    else
      $display("button_decimal_digit_editor_tb failed");
    $finish;
  end

endmodule
